// ===== sv/event_wait_mailbox_top_defines.svh =====
// Assertion macros shared by the event mailbox checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef EVENT_WAIT_MAILBOX_TOP_DEFINES_SVH
`define EVENT_WAIT_MAILBOX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define EWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("event mailbox check failed");

// Next-cycle implication, disabled while reset is asserted
`define EWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("event mailbox check failed");

`endif

// ===== sv/ewm_pkg.sv =====
// Shared constants, status codes and types of the event mailbox.
// Depends on nothing; imported by every module of the block.
package ewm_pkg;

    // Default sizes handed to the top level parameters
    localparam int EVENT_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_LIMIT_DEF  = 256;

    // Field widths
    localparam int OPCODE_W = 1;
    localparam int EVENT_W  = 4;
    localparam int TASK_W   = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // Request kinds
    localparam logic OP_AWAIT  = 1'b0;
    localparam logic OP_SIGNAL = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the accepted request
        logic exec;      // decide, update the event entry, access the word store
        logic load_out;  // move the response into the output register
    } ewm_cmd_t;

    // Lookup that folds a task id into the task range
    typedef logic [TASK_W-1:0] task_table_t [1 << TASK_W];

endpackage

// ===== sv/ewm_ctrl.sv =====
// Controller of the event mailbox: request sequencing and output handshake.
// Depends on ewm_pkg for the command struct.
module ewm_ctrl
    import ewm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ewm_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    // Take a new request when idle, or when the pending response can leave
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Drive datapath commands
    assign cmd.load_in  = accept;
    assign cmd.exec     = (state_reg == S_LOOK);
    assign cmd.load_out = (state_reg == S_RESP) && out_free;

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_LOOK;
            end
            S_LOOK: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) state_next = accept ? S_LOOK : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output valid until the transaction completes
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/ewm_dp.sv =====
// Datapath of the event mailbox: event table, pending word store, response.
// Depends on ewm_pkg; driven by the commands of ewm_ctrl.
module ewm_dp
    import ewm_pkg::*;
#(
    parameter int EVENT_COUNT = EVENT_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TASK_LIMIT  = TASK_LIMIT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ewm_cmd_t                   cmd,
    input  logic                       in_opcode,
    input  logic [EVENT_W-1:0]         in_event_index,
    input  logic [TASK_W-1:0]          in_task_id,
    input  logic signed [DATA_W-1:0]   in_data,
    output logic [STATUS_W-1:0]        out_status,
    output logic                       out_ready_valid,
    output logic [TASK_W-1:0]          out_ready_task,
    output logic signed [DATA_W-1:0]   out_return_value
);

    localparam int EV_IW     = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = EVENT_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(QUEUE_DEPTH);
    localparam logic [EVENT_W:0]   EV_LIMIT  = (EVENT_W + 1)'(EVENT_COUNT);
    localparam logic [ADDR_W-1:0]  ROW_SIZE  = ADDR_W'(QUEUE_DEPTH);

    // Fold every possible task id into the task range
    function automatic task_table_t build_task_table();
        task_table_t t;
        for (int i = 0; i < (1 << TASK_W); i++) begin
            t[i] = TASK_W'(i % TASK_LIMIT);
        end
        return t;
    endfunction

    localparam task_table_t TASK_FOLD = build_task_table();

    // Captured request
    logic                     op_reg;
    logic [EVENT_W-1:0]       ev_reg;
    logic [TASK_W-1:0]        task_reg;
    logic signed [DATA_W-1:0] data_reg;

    // Per-event table
    logic                     present_reg [EVENT_COUNT];
    logic [TASK_W-1:0]        wtask_reg   [EVENT_COUNT];
    logic [PTR_W-1:0]         head_reg    [EVENT_COUNT];
    logic [PTR_W-1:0]         tail_reg    [EVENT_COUNT];
    logic [FILL_W-1:0]        fill_reg    [EVENT_COUNT];

    // Pending word store, one row of QUEUE_DEPTH words per event
    logic signed [DATA_W-1:0] mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] mem_q;

    // Response held between the decision and the output register
    logic [STATUS_W-1:0]      rsp_status_reg;
    logic                     rsp_rv_reg;
    logic [TASK_W-1:0]        rsp_task_reg;
    logic signed [DATA_W-1:0] rsp_val_reg;
    logic                     rsp_mem_reg;

    // Output register
    logic [STATUS_W-1:0]      out_status_reg;
    logic                     out_rv_reg;
    logic [TASK_W-1:0]        out_task_reg;
    logic signed [DATA_W-1:0] out_val_reg;

    logic [EV_IW-1:0]         ev_sel;
    logic                     ev_ok;
    logic                     cur_present;
    logic [TASK_W-1:0]        cur_wtask;
    logic [PTR_W-1:0]         cur_head, cur_tail;
    logic [FILL_W-1:0]        cur_fill;
    logic [STATUS_W-1:0]      res_status;
    logic                     res_rv;
    logic [TASK_W-1:0]        res_task;
    logic signed [DATA_W-1:0] res_val;
    logic                     do_park, do_wake, do_pop, do_push;
    logic [PTR_W-1:0]         mem_ptr;
    logic [ADDR_W-1:0]        mem_addr;

    // Capture the request, folding the task id on the way in
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= in_opcode;
            ev_reg   <= in_event_index;
            task_reg <= TASK_FOLD[in_task_id];
            data_reg <= in_data;
        end
    end

    // Look up the addressed event
    assign ev_sel      = ev_reg[EV_IW-1:0];
    assign ev_ok       = {1'b0, ev_reg} < EV_LIMIT;
    assign cur_present = present_reg[ev_sel];
    assign cur_wtask   = wtask_reg[ev_sel];
    assign cur_head    = head_reg[ev_sel];
    assign cur_tail    = tail_reg[ev_sel];
    assign cur_fill    = fill_reg[ev_sel];

    // Decide the outcome of the request
    always_comb begin
        res_status = ST_INVALID;
        res_rv     = 1'b0;
        res_task   = '0;
        res_val    = '0;
        do_park    = 1'b0;
        do_wake    = 1'b0;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        if (!ev_ok) begin
            res_status = ST_INVALID;
            if (op_reg == OP_AWAIT) begin
                res_rv   = 1'b1;
                res_task = task_reg;
            end
        end else if (op_reg == OP_AWAIT) begin
            if (cur_present) begin
                res_status = ST_BUSY;
                res_rv     = 1'b1;
                res_task   = task_reg;
            end else if (cur_fill == '0) begin
                res_status = ST_BLOCKED;
                do_park    = 1'b1;
            end else begin
                res_status = ST_DELIVERED;
                res_rv     = 1'b1;
                res_task   = task_reg;
                do_pop     = 1'b1;
            end
        end else begin
            if (cur_present) begin
                res_status = ST_DELIVERED;
                res_rv     = 1'b1;
                res_task   = cur_wtask;
                res_val    = data_reg;
                do_wake    = 1'b1;
            end else if (cur_fill >= FILL_FULL) begin
                res_status = ST_DROPPED;
            end else begin
                res_status = ST_QUEUED;
                do_push    = 1'b1;
            end
        end
    end

    // Address the word store at the head on pop, at the tail on push
    assign mem_ptr  = do_pop ? cur_head : cur_tail;
    assign mem_addr = ADDR_W'(ev_sel) * ROW_SIZE + ADDR_W'(mem_ptr);

    always_ff @(posedge aclk) begin
        if (cmd.exec && do_push) mem[mem_addr] <= data_reg;
        if (cmd.exec && do_pop) mem_q <= mem[mem_addr];
    end

    // Update the addressed event entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < EVENT_COUNT; i++) begin
                present_reg[i] <= 1'b0;
                wtask_reg[i]   <= '0;
                head_reg[i]    <= '0;
                tail_reg[i]    <= '0;
                fill_reg[i]    <= '0;
            end
        end else if (cmd.exec) begin
            if (do_park) begin
                present_reg[ev_sel] <= 1'b1;
                wtask_reg[ev_sel]   <= task_reg;
            end
            if (do_wake) begin
                present_reg[ev_sel] <= 1'b0;
                wtask_reg[ev_sel]   <= '0;
            end
            if (do_pop) begin
                head_reg[ev_sel] <= (cur_head == PTR_LAST) ? '0 : cur_head + 1'b1;
                fill_reg[ev_sel] <= cur_fill - 1'b1;
            end
            if (do_push) begin
                tail_reg[ev_sel] <= (cur_tail == PTR_LAST) ? '0 : cur_tail + 1'b1;
                fill_reg[ev_sel] <= cur_fill + 1'b1;
            end
        end
    end

    // Hold the response while the popped word is read
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rsp_status_reg <= res_status;
            rsp_rv_reg     <= res_rv;
            rsp_task_reg   <= res_task;
            rsp_val_reg    <= res_val;
            rsp_mem_reg    <= do_pop;
        end
    end

    // Load the output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= rsp_status_reg;
            out_rv_reg     <= rsp_rv_reg;
            out_task_reg   <= rsp_task_reg;
            out_val_reg    <= rsp_mem_reg ? mem_q : rsp_val_reg;
        end
    end

    assign out_status       = out_status_reg;
    assign out_ready_valid  = out_rv_reg;
    assign out_ready_task   = out_task_reg;
    assign out_return_value = out_val_reg;

endmodule

// ===== sv/event_wait_mailbox_top.sv =====
// Event mailbox: each event number has one waiter slot and a queue of
// QUEUE_DEPTH pending words. Every request gives exactly one response. The
// response passes the request, response and output registers before it shows
// on the master side. A new request is taken only while idle or as the pending
// response moves into the output register: the look-up step reads and updates
// the addressed event entry and starts the single-port word store access, the
// response step registers the popped word into the output register. The word
// store needs no clearing after reset, since a word is read only after it was
// queued; the block accepts requests right out of reset.
// Depends on ewm_pkg, ewm_ctrl and ewm_dp.
module event_wait_mailbox_top
    import ewm_pkg::*;
#(
    parameter int EVENT_COUNT = EVENT_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TASK_LIMIT  = TASK_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // event_index[3:0], task_id[11:4], data[43:12], zero pad
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ready_task[7:0], return_value[39:8]
    output logic [3:0]  m_tuser    // status[2:0], ready_valid[3]
);

    ewm_cmd_t                 cmd;
    logic [STATUS_W-1:0]      out_status;
    logic                     out_ready_valid;
    logic [TASK_W-1:0]        out_ready_task;
    logic signed [DATA_W-1:0] out_return_value;

    ewm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ewm_dp #(
        .EVENT_COUNT (EVENT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_LIMIT  (TASK_LIMIT)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .in_opcode        (s_tuser[0]),
        .in_event_index   (s_tdata[3:0]),
        .in_task_id       (s_tdata[11:4]),
        .in_data          (s_tdata[43:12]),
        .out_status       (out_status),
        .out_ready_valid  (out_ready_valid),
        .out_ready_task   (out_ready_task),
        .out_return_value (out_return_value)
    );

    // Pack the response
    assign m_tdata = {out_return_value, out_ready_task};
    assign m_tuser = {out_ready_valid, out_status};

endmodule

// ===== sv/ewm_checker.sv =====
// Port-level checks of the event mailbox, bound to the top level.
// Depends on ewm_pkg and event_wait_mailbox_top_defines.svh.
`include "event_wait_mailbox_top_defines.svh"

module ewm_checker
    import ewm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser
);

    logic [STATUS_W-1:0] rsp_status;
    logic                rsp_ready;
    logic                rsp_may_ready;
    logic                rsp_stall;

    // Split the response sideband
    assign rsp_status    = m_tuser[2:0];
    assign rsp_ready     = m_tuser[3];
    assign rsp_may_ready = (rsp_status == ST_DELIVERED) || (rsp_status == ST_INVALID) ||
                           (rsp_status == ST_BUSY);
    assign rsp_stall     = m_tvalid && !m_tready;

    // A stalled response holds
    `EWM_ASSERT_NEXT(a_resp_hold, aclk, aresetn, rsp_stall, m_tvalid && $stable({m_tuser, m_tdata}))

    // A response that newly appears traces back to an accepted transaction
    `EWM_ASSERT_IMPL(a_resp_origin, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 3))

    // Only delivered, invalid and busy responses ready a task
    `EWM_ASSERT_IMPL(a_ready_flag, aclk, aresetn, m_tvalid && rsp_ready, rsp_may_ready)

    // Without a readied task the payload is all zero
    `EWM_ASSERT_IMPL(a_idle_payload, aclk, aresetn, m_tvalid && !rsp_ready, m_tdata == 40'd0)

endmodule

bind event_wait_mailbox_top ewm_checker u_ewm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
